>>> design/nicc_pkg.sv
// ----------------------------------------------------------------------------
// nicc_pkg
// Shared types and constants for node id compaction and cliques.
// ----------------------------------------------------------------------------
package nicc_pkg;

    localparam int MAX_RANKS = 256;
    localparam int CNT_W     = 9;
    localparam int DIV_W     = 9;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] REG_NO_LOCAL  = 2'd0;
    localparam logic [1:0] REG_CLIQUES   = 2'd1;
    localparam logic [1:0] REG_ODD_EVEN  = 2'd2;
    localparam logic [1:0] REG_BY_BLOCK  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [30:0] raw_node_id;
        logic [7:0]  rank_index;
    } cmd_t;

    typedef struct packed {
        logic [7:0] node_id;
        logic [8:0] node_count;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic        by_rank;
        logic [30:0] key;
    } query_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] dense;
    } link_t;

    typedef struct packed {
        logic        en;
        logic [7:0]  idx;
        logic [30:0] raw;
        logic [7:0]  dense;
    } wr_t;

endpackage

>>> design/nicc_cell.sv
// ----------------------------------------------------------------------------
// nicc_cell
// One rank slot: holds raw and dense id, matches the query, passes the hit on.
// ----------------------------------------------------------------------------
module nicc_cell #(
    parameter int INDEX = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  nicc_pkg::wr_t           wr,
    input  nicc_pkg::query_t        query,
    input  logic [nicc_pkg::CNT_W-1:0] count,
    input  nicc_pkg::link_t         link_in,
    output nicc_pkg::link_t         link_out
);

    logic [30:0]     raw_reg;
    logic [7:0]      dense_reg;
    nicc_pkg::link_t link_reg;
    logic            own_hit;

    assign own_hit = (count > nicc_pkg::CNT_W'(INDEX)) &&
                     (query.by_rank ? (query.key[7:0] == 8'(INDEX))
                                    : (query.key == raw_reg));

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.idx == 8'(INDEX))
        begin
            raw_reg   <= wr.raw;
            dense_reg <= wr.dense;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else if (link_in.hit)
        begin
            link_reg <= link_in;
        end
        else
        begin
            link_reg.hit   <= own_hit;
            link_reg.dense <= dense_reg;
        end
    end

    assign link_out = link_reg;

endmodule

>>> design/nicc_div.sv
// ----------------------------------------------------------------------------
// nicc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nicc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [nicc_pkg::DIV_W-1:0] dividend,
    input  logic [nicc_pkg::DIV_W-1:0] divisor,
    output logic [nicc_pkg::DIV_W-1:0] quotient,
    output logic [nicc_pkg::DIV_W-1:0] remainder,
    output logic                      done
);

    localparam int W = nicc_pkg::DIV_W;

    logic [W-1:0]         quo_reg;
    logic [W-1:0]         rem_reg;
    logic [W-1:0]         dvs_reg;
    logic [$clog2(W+1)-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [W:0]           trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= ($clog2(W+1))'(W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[W-2:0], fits};
            rem_reg <= fits ? W'(trial - {1'b0, dvs_reg}) : trial[W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

>>> design/node_id_compaction_and_cliques_top.sv
// ----------------------------------------------------------------------------
// node_id_compaction_and_cliques_top
// Dense node id renumbering over a chain of rank cells, with clique split.
//
// Command channel: an item transfers when start is high and busy is low.
// op load appends one raw id for the next rank; op read returns the final
// node id of rank_index; op restart empties the tables. Each item yields one
// result on result, marked by a one-cycle done strobe; it cannot be held off.
// Load and read send the query down the chain of 256 cells, one cell per
// cycle; a read that splits into cliques adds
// one divider pass round-robin or two passes plus a multiply
// by blocks. Restart, unused op and full-table loads go straight to
// the reply. One item is in flight at a time.
// Configuration writes take effect at once on cfg_we; write them while idle.
// Reset empties the tables and sets the registers to their defaults; cell
// contents stay undefined and are never read before written.
// ----------------------------------------------------------------------------
module node_id_compaction_and_cliques_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  nicc_pkg::cmd_t    cmd,
    output logic              done,
    output nicc_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_data
);

    localparam int N  = nicc_pkg::MAX_RANKS;
    localparam int CW = nicc_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_DIVR, S_DIVA, S_MUL, S_CMP, S_DIVB, S_REPLY
    } state_t;

    state_t              state_reg;
    nicc_pkg::cmd_t      cmd_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       dense_next_reg;
    logic                no_local_reg;
    logic [8:0]          cliques_reg;
    logic                odd_even_reg;
    logic                by_block_reg;
    logic [CW-1:0]       wait_reg;
    logic [7:0]          nid_reg;
    logic [1:0]          status_reg;
    nicc_pkg::result_t   result_reg;
    logic                done_reg;
    logic                div_go_reg;
    logic [8:0]          div_a_reg;
    logic [8:0]          div_b_reg;
    logic [8:0]          blk_reg;
    logic [8:0]          rem_reg;
    logic [8:0]          mid_reg;

    logic [8:0]          quo;
    logic [8:0]          rmd;
    logic                div_done;
    logic [8:0]          req;
    logic [8:0]          eff;
    logic                self_map;
    logic                split;
    logic [8:0]          nodes;
    logic                chain_end;
    logic [7:0]          dense;
    nicc_pkg::query_t    query;
    nicc_pkg::wr_t       wr;
    nicc_pkg::link_t     links [0:N];

    assign req      = (cliques_reg > 9'd1) ? cliques_reg : (odd_even_reg ? 9'd2 : 9'd1);
    assign eff      = (req > count_reg) ? count_reg : req;
    assign self_map = no_local_reg || count_reg == 9'd1;
    assign split    = !self_map && dense_next_reg == 9'd1 && eff > 9'd1;
    assign nodes    = (count_reg == '0) ? 9'd0 :
                      self_map ? count_reg :
                      split ? eff : dense_next_reg;

    assign chain_end = state_reg == S_SEARCH && wait_reg == CW'(N);
    assign dense     = links[N].hit ? links[N].dense : dense_next_reg[7:0];

    assign query.by_rank = cmd_reg.op == nicc_pkg::OP_READ;
    assign query.key     = query.by_rank ? {23'd0, cmd_reg.rank_index} : cmd_reg.raw_node_id;

    assign wr.en    = chain_end && cmd_reg.op == nicc_pkg::OP_LOAD;
    assign wr.idx   = count_reg[7:0];
    assign wr.raw   = cmd_reg.raw_node_id;
    assign wr.dense = dense;

    assign links[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        nicc_cell #(.INDEX(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr       (wr),
            .query    (query),
            .count    (count_reg),
            .link_in  (links[i]),
            .link_out (links[i+1])
        );
    end

    nicc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go_reg),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .quotient  (quo),
        .remainder (rmd),
        .done      (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            dense_next_reg <= '0;
            no_local_reg   <= 1'b0;
            cliques_reg    <= 9'd1;
            odd_even_reg   <= 1'b0;
            by_block_reg   <= 1'b0;
            wait_reg       <= '0;
            done_reg       <= 1'b0;
            div_go_reg     <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            div_go_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    nicc_pkg::REG_NO_LOCAL: no_local_reg <= cfg_data[0];
                    nicc_pkg::REG_CLIQUES:  cliques_reg  <= cfg_data;
                    nicc_pkg::REG_ODD_EVEN: odd_even_reg <= cfg_data[0];
                    nicc_pkg::REG_BY_BLOCK: by_block_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg    <= cmd;
                        wait_reg   <= '0;
                        nid_reg    <= '0;
                        status_reg <= nicc_pkg::ST_OK;
                        case (cmd.op)
                            nicc_pkg::OP_LOAD:
                            begin
                                if (count_reg == CW'(N))
                                begin
                                    status_reg <= nicc_pkg::ST_FULL;
                                    state_reg  <= S_REPLY;
                                end
                                else
                                begin
                                    state_reg <= S_SEARCH;
                                end
                            end
                            nicc_pkg::OP_READ:
                            begin
                                state_reg <= S_SEARCH;
                            end
                            nicc_pkg::OP_RESTART:
                            begin
                                count_reg      <= '0;
                                dense_next_reg <= '0;
                                state_reg      <= S_REPLY;
                            end
                            default:
                            begin
                                state_reg <= S_REPLY;
                            end
                        endcase
                    end
                end
                S_SEARCH:
                begin
                    wait_reg <= wait_reg + 1'b1;
                    if (chain_end)
                    begin
                        state_reg <= S_REPLY;
                        if (cmd_reg.op == nicc_pkg::OP_LOAD)
                        begin
                            if (!links[N].hit)
                            begin
                                dense_next_reg <= dense_next_reg + 1'b1;
                            end
                            count_reg <= count_reg + 1'b1;
                            nid_reg   <= no_local_reg ? count_reg[7:0] : dense;
                        end
                        else if ({1'b0, cmd_reg.rank_index} >= count_reg)
                        begin
                            status_reg <= nicc_pkg::ST_RANGE;
                        end
                        else if (self_map)
                        begin
                            nid_reg <= cmd_reg.rank_index;
                        end
                        else if (!split)
                        begin
                            nid_reg <= links[N].dense;
                        end
                        else if (!by_block_reg)
                        begin
                            div_a_reg  <= {1'b0, cmd_reg.rank_index};
                            div_b_reg  <= eff;
                            div_go_reg <= 1'b1;
                            state_reg  <= S_DIVR;
                        end
                        else
                        begin
                            div_a_reg  <= count_reg;
                            div_b_reg  <= eff;
                            div_go_reg <= 1'b1;
                            state_reg  <= S_DIVA;
                        end
                    end
                end
                S_DIVR:
                begin
                    if (div_done)
                    begin
                        nid_reg   <= rmd[7:0];
                        state_reg <= S_REPLY;
                    end
                end
                S_DIVA:
                begin
                    if (div_done)
                    begin
                        blk_reg   <= quo;
                        rem_reg   <= rmd;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    mid_reg   <= 9'((blk_reg + 9'd1) * rem_reg);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if ({1'b0, cmd_reg.rank_index} < mid_reg)
                    begin
                        div_a_reg <= {1'b0, cmd_reg.rank_index};
                        div_b_reg <= blk_reg + 9'd1;
                    end
                    else
                    begin
                        div_a_reg <= {1'b0, cmd_reg.rank_index} - rem_reg;
                        div_b_reg <= blk_reg;
                    end
                    div_go_reg <= 1'b1;
                    state_reg  <= S_DIVB;
                end
                S_DIVB:
                begin
                    if (div_done)
                    begin
                        nid_reg   <= quo[7:0];
                        state_reg <= S_REPLY;
                    end
                end
                S_REPLY:
                begin
                    result_reg.node_id    <= nid_reg;
                    result_reg.node_count <= nodes;
                    result_reg.status     <= status_reg;
                    done_reg              <= 1'b1;
                    state_reg             <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> design/nicc_checker.sv
// ----------------------------------------------------------------------------
// nicc_checker
// Port-level checks on command and result transfers.
// ----------------------------------------------------------------------------
module nicc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input nicc_pkg::cmd_t    cmd,
    input logic              done,
    input nicc_pkg::result_t result
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == nicc_pkg::ST_OK || result.status == nicc_pkg::ST_RANGE ||
                  result.status == nicc_pkg::ST_FULL))
        else $error("bad status");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == nicc_pkg::OP_RESTART) |=> ##1
        (done && result.node_count == 9'd0 && result.node_id == 8'd0))
        else $error("restart result wrong");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == nicc_pkg::OP_READ) |=> (busy && !done))
        else $error("read not in flight");

    a_nodes: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.node_count <= 9'd256)
        else $error("node count too large");

endmodule

bind node_id_compaction_and_cliques_top nicc_checker u_nicc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
